>>> hw/rtl/button_click_hold_detector_macros.svh
// Assertion helpers shared by the detector's RTL files.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define BCHD_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("bchd: check failed");

// Consequent must hold in the cycle after the antecedent.
`define BCHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bchd: check failed");

`endif

>>> hw/rtl/bchd_pkg.sv
package bchd_pkg;

	// Defaults and fixed widths
	localparam int BUTTONS_DEF = 2;
	localparam int IDX_MAX_W   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int HOLD_LEVELS = 5;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_ACTIVE_LEVEL  = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
	localparam logic [2:0] REG_HOLD_PERIOD   = 3'd2;
	localparam logic [2:0] REG_RELEASE_DELAY = 3'd3;
	localparam logic [2:0] REG_HOLD_MARK     = 3'd4;

	// Event kinds
	localparam logic KIND_HOLD    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        active_level;
		logic [7:0]  debounce_samples;
		logic [15:0] hold_period_ticks;
		logic [15:0] release_delay_ticks;
		logic [7:0]  hold_mark_base;
	} cfg_t;

	typedef struct packed {
		logic                 kind;
		logic [IDX_MAX_W-1:0] idx;
		logic [2:0]           level;
		logic [7:0]           press;
		logic [7:0]           hold;
		logic                 last;
	} event_t;

endpackage

>>> hw/rtl/bchd_regs.sv
module bchd_regs import bchd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic        active_level_q;
	logic [7:0]  debounce_q;
	logic [15:0] hold_period_q;
	logic [15:0] release_delay_q;
	logic [7:0]  hold_mark_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q  <= 1'b0;
			debounce_q      <= 8'd5;
			hold_period_q   <= 16'd1000;
			release_delay_q <= 16'd500;
			hold_mark_q     <= 8'd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ACTIVE_LEVEL:  active_level_q  <= pwdata[0];
				REG_DEBOUNCE:      debounce_q      <= pwdata[7:0];
				REG_HOLD_PERIOD:   hold_period_q   <= pwdata[15:0];
				REG_RELEASE_DELAY: release_delay_q <= pwdata[15:0];
				REG_HOLD_MARK:     hold_mark_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_ACTIVE_LEVEL:  prdata = {{(DATA_W-1){1'b0}}, active_level_q};
			REG_DEBOUNCE:      prdata = {{(DATA_W-8){1'b0}}, debounce_q};
			REG_HOLD_PERIOD:   prdata = {{(DATA_W-16){1'b0}}, hold_period_q};
			REG_RELEASE_DELAY: prdata = {{(DATA_W-16){1'b0}}, release_delay_q};
			REG_HOLD_MARK:     prdata = {{(DATA_W-8){1'b0}}, hold_mark_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.active_level        = active_level_q;
	assign cfg.debounce_samples    = debounce_q;
	assign cfg.hold_period_ticks   = hold_period_q;
	assign cfg.release_delay_ticks = release_delay_q;
	assign cfg.hold_mark_base      = hold_mark_q;

endmodule

>>> hw/rtl/bchd_front.sv
`include "button_click_hold_detector_macros.svh"

module bchd_front import bchd_pkg::*; #(
	parameter int BUTTONS = BUTTONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BUTTONS-1:0] button_levels,
	output logic               push_valid,
	output event_t             push_item,
	input  logic               push_ready
);

	localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	// Per-button state and the shared hold and release timers
	logic       stable_q [BUTTONS];
	logic       cand_q   [BUTTONS];
	logic [7:0] run_q    [BUTTONS];
	logic [7:0] press_q  [BUTTONS];
	logic [7:0] hold_q   [BUTTONS];
	logic       held_q   [BUTTONS];
	logic       rel_q    [BUTTONS];
	logic [15:0] hc_q;
	logic [15:0] rc_q;

	// Next state
	logic       stable_n [BUTTONS];
	logic       cand_n   [BUTTONS];
	logic [7:0] run_n    [BUTTONS];
	logic [7:0] press_n  [BUTTONS];
	logic [7:0] hold_n   [BUTTONS];
	logic       held_n   [BUTTONS];
	logic       rel_n    [BUTTONS];
	logic       pressed_w[BUTTONS];
	logic [7:0] mark_d   [BUTTONS];
	logic [15:0] hc_n;
	logic [15:0] rc_n;

	// Events found on this tick
	logic [BUTTONS-1:0] ev_mask;
	logic       ev_kind  [BUTTONS];
	logic [2:0] ev_level [BUTTONS];
	logic [7:0] ev_press [BUTTONS];
	logic [7:0] ev_hold  [BUTTONS];

	// Event snapshot, drained one item a cycle while push_ready is high
	logic [BUTTONS-1:0] pend_q;
	logic       evk_q [BUTTONS];
	logic [2:0] evl_q [BUTTONS];
	logic [7:0] evp_q [BUTTONS];
	logic [7:0] evh_q [BUTTONS];

	logic [7:0]  need;
	logic [15:0] hold_per;
	logic [15:0] rel_per;
	logic        hold_now, rel_loaded, fire, any_held;
	logic        accept, push;
	logic [IDX_W-1:0]   sel;
	logic [BUTTONS-1:0] sel_bit;
	logic [BUTTONS-1:0] hold_pend;

	assign need     = (cfg.debounce_samples == 8'd0) ? 8'd1 : cfg.debounce_samples;
	assign hold_per = (cfg.hold_period_ticks == 16'd0) ? 16'd1 : cfg.hold_period_ticks;
	assign rel_per  = (cfg.release_delay_ticks == 16'd0) ? 16'd1 : cfg.release_delay_ticks;

	assign in_ready = (pend_q == '0);
	assign accept   = in_valid && in_ready;

	// Tick evaluation: debounce, hold timer, release timer
	always_comb begin
		hold_now   = 1'b0;
		rel_loaded = 1'b0;
		any_held   = 1'b0;
		hc_n       = hc_q;
		rc_n       = rc_q;
		for (int i = 0; i < BUTTONS; i++) begin
			pressed_w[i] = (button_levels[i] == cfg.active_level);
			stable_n[i]  = stable_q[i];
			cand_n[i]    = cand_q[i];
			run_n[i]     = run_q[i];
			press_n[i]   = press_q[i];
			hold_n[i]    = hold_q[i];
			held_n[i]    = held_q[i];
			rel_n[i]     = rel_q[i];
			mark_d[i]    = 8'd0;
			ev_mask[i]   = 1'b0;
			ev_kind[i]   = KIND_HOLD;
			ev_level[i]  = 3'd0;
			ev_press[i]  = 8'd0;
			ev_hold[i]   = 8'd0;
			if (pressed_w[i] != cand_q[i]) begin
				cand_n[i] = pressed_w[i];
				run_n[i]  = 8'd1;
			end else if (run_q[i] != 8'hFF) begin
				run_n[i] = run_q[i] + 8'd1;
			end
			if ((cand_n[i] != stable_q[i]) && (run_n[i] >= need)) begin
				stable_n[i] = cand_n[i];
				if (cand_n[i]) begin
					press_n[i] = press_q[i] + 8'd1;
					if (!held_q[i])
						hold_now = 1'b1;
					held_n[i] = 1'b1;
					rel_n[i]  = 1'b0;
				end else begin
					rel_n[i]   = 1'b1;
					held_n[i]  = 1'b0;
					rel_loaded = 1'b1;
				end
			end
		end

		// hold timer; a new first press fires at once
		fire = hold_now;
		if (!hold_now && (hc_q != 16'd0)) begin
			hc_n = hc_q - 16'd1;
			fire = (hc_q == 16'd1);
		end
		if (fire) begin
			for (int i = 0; i < BUTTONS; i++) begin
				if (held_n[i]) begin
					any_held  = 1'b1;
					hold_n[i] = hold_q[i] + 8'd1;
					mark_d[i] = hold_n[i] - cfg.hold_mark_base;
					if (mark_d[i] < 8'(HOLD_LEVELS)) begin
						ev_mask[i]  = 1'b1;
						ev_kind[i]  = KIND_HOLD;
						ev_level[i] = mark_d[i][2:0] + 3'd1;
						ev_press[i] = press_n[i];
						ev_hold[i]  = hold_n[i];
					end
				end
			end
			hc_n = any_held ? hold_per : 16'd0;
		end

		// release timer; summaries on expiry
		if (rel_loaded) begin
			rc_n = rel_per;
		end else if (rc_q != 16'd0) begin
			rc_n = rc_q - 16'd1;
			if (rc_q == 16'd1) begin
				for (int i = 0; i < BUTTONS; i++) begin
					if (rel_n[i]) begin
						ev_mask[i]  = 1'b1;
						ev_kind[i]  = KIND_SUMMARY;
						ev_level[i] = 3'd0;
						ev_press[i] = press_n[i];
						ev_hold[i]  = hold_n[i];
						press_n[i]  = 8'd0;
						hold_n[i]   = 8'd0;
						held_n[i]   = 1'b0;
						rel_n[i]    = 1'b0;
					end
				end
			end
		end
	end

	// State update on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				stable_q[i] <= 1'b0;
				cand_q[i]   <= 1'b0;
				run_q[i]    <= 8'd0;
				press_q[i]  <= 8'd0;
				hold_q[i]   <= 8'd0;
				held_q[i]   <= 1'b0;
				rel_q[i]    <= 1'b0;
			end
			hc_q <= 16'd0;
			rc_q <= 16'd0;
		end else if (accept) begin
			for (int i = 0; i < BUTTONS; i++) begin
				stable_q[i] <= stable_n[i];
				cand_q[i]   <= cand_n[i];
				run_q[i]    <= run_n[i];
				press_q[i]  <= press_n[i];
				hold_q[i]   <= hold_n[i];
				held_q[i]   <= held_n[i];
				rel_q[i]    <= rel_n[i];
			end
			hc_q <= hc_n;
			rc_q <= rc_n;
		end
	end

	// Hold events go out before summaries, lowest button first within each kind
	always_comb begin
		sel = '0;
		for (int i = 0; i < BUTTONS; i++)
			hold_pend[i] = pend_q[i] && (evk_q[i] == KIND_HOLD);
		for (int i = BUTTONS - 1; i >= 0; i--) begin
			if (pend_q[i])
				sel = IDX_W'(i);
		end
		if (hold_pend != '0) begin
			for (int i = BUTTONS - 1; i >= 0; i--) begin
				if (hold_pend[i])
					sel = IDX_W'(i);
			end
		end
		for (int i = 0; i < BUTTONS; i++)
			sel_bit[i] = (sel == IDX_W'(i));
	end

	assign push_valid      = (pend_q != '0);
	assign push            = push_valid && push_ready;
	assign push_item.kind  = evk_q[sel];
	assign push_item.idx   = IDX_MAX_W'(sel);
	assign push_item.level = evl_q[sel];
	assign push_item.press = evp_q[sel];
	assign push_item.hold  = evh_q[sel];
	assign push_item.last  = ((pend_q & ~sel_bit) == '0);

	// Pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (accept)
			pend_q <= ev_mask;
		else if (push)
			pend_q <= pend_q & ~sel_bit;
	end

	// Event payload snapshot
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < BUTTONS; i++) begin
				evk_q[i] <= ev_kind[i];
				evl_q[i] <= ev_level[i];
				evp_q[i] <= ev_press[i];
				evh_q[i] <= ev_hold[i];
			end
		end
	end

	`BCHD_ASSERT_NEXT(a_busy_after_events, clk, arst_n, accept && (ev_mask != '0), !in_ready)
	`BCHD_ASSERT_NEXT(a_free_after_last, clk, arst_n, push && push_item.last, in_ready)

endmodule

>>> hw/rtl/bchd_queue.sv
`include "button_click_hold_detector_macros.svh"

module bchd_queue import bchd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	input  event_t push_item,
	output logic   push_ready,
	output logic   pop_valid,
	output event_t pop_item,
	input  logic   pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	event_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	`BCHD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))

endmodule

>>> hw/rtl/bchd_back.sv
module bchd_back import bchd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pop_valid,
	input  event_t pop_item,
	output logic   pop_ready,
	output logic   out_valid,
	output event_t out_item,
	input  logic   out_ready
);

	logic   out_valid_q;
	event_t out_item_q;

	assign pop_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop_ready)
			out_valid_q <= pop_valid;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid)
			out_item_q <= pop_item;
	end

endmodule

>>> hw/rtl/button_click_hold_detector.sv
// Channel   Handshake              Payload
// cfg       psel/penable/pready    paddr, pwdata, prdata (APB, reg i at 4*i)
// in        in_valid/in_ready      button_levels
// out       out_valid/out_ready    event_kind, button_index, hold_level,
//                                  press_total, hold_total, last_event
//
// A tick is evaluated in the cycle it is accepted; its k events (0..BUTTONS)
// then drain one per cycle into the queue while push_ready is high.
// in_ready is low while the front still holds undrained events of a tick.
// The queue (DEPTH entries) and the output register absorb DEPTH + 1 events
// of out_ready stall; beyond that the front waits on push_ready.
// Reset (arst_n, async) clears all debounce state, tallies, timers and queue.
module button_click_hold_detector import bchd_pkg::*; #(
	parameter int BUTTONS = BUTTONS_DEF,
	parameter int DEPTH   = QUEUE_DEPTH,
	localparam int IDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BUTTONS-1:0] button_levels,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               event_kind,
	output logic [IDX_W-1:0]   button_index,
	output logic [2:0]         hold_level,
	output logic [7:0]         press_total,
	output logic [7:0]         hold_total,
	output logic               last_event
);

	cfg_t   cfg;
	logic   push_valid, push_ready, pop_valid, pop_ready;
	event_t push_item, pop_item, out_item;

	bchd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bchd_front #(.BUTTONS(BUTTONS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_levels (button_levels),
		.push_valid    (push_valid),
		.push_item     (push_item),
		.push_ready    (push_ready)
	);

	bchd_queue #(.DEPTH(DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	bchd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (out_ready)
	);

	// Result fields
	assign event_kind   = out_item.kind;
	assign button_index = out_item.idx[IDX_W-1:0];
	assign hold_level   = out_item.level;
	assign press_total  = out_item.press;
	assign hold_total   = out_item.hold;
	assign last_event   = out_item.last;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import bchd_pkg::*;

	localparam int NB          = BUTTONS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int SHOW_MAX    = 10;

	// Predicts the events each tick causes and checks them in order
	class tick_scoreboard;
		bit        active_level;
		bit [7:0]  debounce_samples;
		bit [15:0] hold_period;
		bit [15:0] release_delay;
		bit [7:0]  mark_base;

		bit        stable_lvl[NB];
		bit        cand_lvl[NB];
		bit [7:0]  run_len[NB];
		bit [7:0]  presses[NB];
		bit [7:0]  holds[NB];
		bit        held[NB];
		bit        released[NB];
		bit [16:0] hold_cd;
		bit [16:0] release_cd;

		event_t    due_events[$];
		int        errors;

		function new();
			active_level     = 1'b0;
			debounce_samples = 8'd5;
			hold_period      = 16'd1000;
			release_delay    = 16'd500;
			mark_base        = 8'd1;
			for (int i = 0; i < NB; i++) begin
				stable_lvl[i] = 1'b0;
				cand_lvl[i]   = 1'b0;
				run_len[i]    = '0;
				presses[i]    = '0;
				holds[i]      = '0;
				held[i]       = 1'b0;
				released[i]   = 1'b0;
			end
			hold_cd    = '0;
			release_cd = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_ACTIVE_LEVEL:  active_level     = value[0];
				REG_DEBOUNCE:      debounce_samples = value[7:0];
				REG_HOLD_PERIOD:   hold_period      = value[15:0];
				REG_RELEASE_DELAY: release_delay    = value[15:0];
				REG_HOLD_MARK:     mark_base        = value[7:0];
				default: ;
			endcase
		endfunction

		function event_t make_event(logic kind, int i, bit [2:0] lvl);
			event_t ev;
			ev       = '0;
			ev.kind  = kind;
			ev.idx   = IDX_MAX_W'(i);
			ev.level = lvl;
			ev.press = presses[i];
			ev.hold  = holds[i];
			return ev;
		endfunction

		// One tick: debounce, then hold timer, then release timer
		function void note_tick(logic [NB-1:0] levels);
			event_t    burst[$];
			bit        hold_now;
			bit        rel_loaded;
			bit        fire;
			bit        any;
			bit        pressed;
			bit [7:0]  need;
			bit [7:0]  d;
			bit [16:0] hold_per;
			bit [16:0] rel_per;
			hold_now   = 1'b0;
			rel_loaded = 1'b0;
			need       = (debounce_samples == 0) ? 8'd1 : debounce_samples;
			hold_per   = (hold_period == 0) ? 17'd1 : {1'b0, hold_period};
			rel_per    = (release_delay == 0) ? 17'd1 : {1'b0, release_delay};

			for (int i = 0; i < NB; i++) begin
				pressed = (levels[i] == active_level);
				if (pressed != cand_lvl[i]) begin
					cand_lvl[i] = pressed;
					run_len[i]  = 8'd1;
				end else if (run_len[i] != 8'd255) begin
					run_len[i]++;
				end
				if (cand_lvl[i] != stable_lvl[i] && run_len[i] >= need) begin
					stable_lvl[i] = cand_lvl[i];
					if (stable_lvl[i]) begin
						presses[i]++;
						if (!held[i])
							hold_now = 1'b1;
						held[i]     = 1'b1;
						released[i] = 1'b0;
					end else begin
						released[i] = 1'b1;
						held[i]     = 1'b0;
						release_cd  = rel_per;
						rel_loaded  = 1'b1;
					end
				end
			end

			// hold timer; a fresh press fires it at once
			fire = hold_now;
			if (!fire && hold_cd != 0) begin
				hold_cd--;
				if (hold_cd == 0)
					fire = 1'b1;
			end
			if (fire) begin
				any = 1'b0;
				for (int i = 0; i < NB; i++) begin
					if (held[i]) begin
						any = 1'b1;
						holds[i]++;
						d = holds[i] - mark_base;
						if (d < 8'd5)
							burst.push_back(make_event(KIND_HOLD, i, 3'(d + 8'd1)));
					end
				end
				hold_cd = any ? hold_per : 17'd0;
			end

			// release timer: summaries for released buttons, then clear them
			if (!rel_loaded && release_cd != 0) begin
				release_cd--;
				if (release_cd == 0) begin
					for (int i = 0; i < NB; i++) begin
						if (released[i]) begin
							burst.push_back(make_event(KIND_SUMMARY, i, 3'd0));
							presses[i]  = '0;
							holds[i]    = '0;
							held[i]     = 1'b0;
							released[i] = 1'b0;
						end
					end
				end
			end

			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
			foreach (burst[k])
				due_events.push_back(burst[k]);
		endfunction

		function void check_event(event_t got);
			event_t want;
			if (due_events.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("tb: unexpected event kind %0d idx %0d lvl %0d press %0d hold %0d",
						got.kind, got.idx, got.level, got.press, got.hold);
				return;
			end
			want = due_events.pop_front();
			if (got.kind !== want.kind || got.idx !== want.idx || got.level !== want.level ||
					got.press !== want.press || got.hold !== want.hold ||
					got.last !== want.last) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("tb: mismatch exp k%0d i%0d l%0d p%0d h%0d e%0d got k%0d i%0d l%0d p%0d h%0d e%0d",
						want.kind, want.idx, want.level, want.press, want.hold, want.last,
						got.kind, got.idx, got.level, got.press, got.hold, got.last);
			end
		endfunction

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [NB-1:0]     button_levels;
	logic              out_valid;
	logic              out_ready;
	logic              event_kind;
	logic [0:0]        button_index;
	logic [2:0]        hold_level;
	logic [7:0]        press_total;
	logic [7:0]        hold_total;
	logic              last_event;

	tick_scoreboard sb;
	int             idle_cycles;
	bit             send_calm;
	bit             recv_calm;
	logic [NB-1:0]  raw_bits;
	int             run_left[NB];
	int             cur_need;
	int             cur_long;

	button_click_hold_detector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_levels (button_levels),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.button_index  (button_index),
		.hold_level    (hold_level),
		.press_total   (press_total),
		.hold_total    (hold_total),
		.last_event    (last_event)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// All handshakes observed here, in one place per edge
	always @(posedge clk) begin
		event_t got;
		bit     moved;
		if (arst_n) begin
			moved = 1'b0;
			if (psel && penable && pwrite && pready) begin
				sb.write_reg(paddr[4:2], pwdata);
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				sb.note_tick(button_levels);
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				got       = '0;
				got.kind  = event_kind;
				got.idx   = IDX_MAX_W'(button_index);
				got.level = hold_level;
				got.press = press_total;
				got.hold  = hold_total;
				got.last  = last_event;
				sb.check_event(got);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// Wait draw with occasional stretches of no idling
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// Result side: random stalls per item
	initial begin
		int w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			w = draw_gap(recv_calm);
			@(negedge clk);
			if (w > 0) begin
				out_ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Sender stops and waits for all outstanding events, then lets the front finish
	task automatic drain();
		drop_valid();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_tick(logic [NB-1:0] levels);
		int w;
		w = draw_gap(send_calm);
		@(negedge clk);
		if (w > 0) begin
			in_valid = 1'b0;
			repeat (w) @(negedge clk);
		end
		in_valid      = 1'b1;
		button_levels = levels;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic configure(bit al, logic [7:0] deb, logic [15:0] hp, logic [15:0] rd,
			logic [7:0] base);
		drain();
		reg_write(REG_ACTIVE_LEVEL, DATA_W'(al));
		reg_write(REG_DEBOUNCE, DATA_W'(deb));
		reg_write(REG_HOLD_PERIOD, DATA_W'(hp));
		reg_write(REG_RELEASE_DELAY, DATA_W'(rd));
		reg_write(REG_HOLD_MARK, DATA_W'(base));
		cur_need = (deb == 0) ? 1 : int'(deb);
	endtask

	// Per-button runs of steady raw levels: mostly clean presses and releases,
	// some bounces no longer than the debounce, some very long runs
	function automatic logic [NB-1:0] next_levels();
		int r;
		for (int i = 0; i < NB; i++) begin
			if (run_left[i] == 0) begin
				raw_bits[i] = ~raw_bits[i];
				r = $urandom_range(0, 9);
				if (r < 2)
					run_left[i] = $urandom_range(1, cur_need);
				else if (r < 4)
					run_left[i] = cur_need + $urandom_range(0, cur_long);
				else
					run_left[i] = cur_need + $urandom_range(0, 12);
			end
			run_left[i]--;
		end
		if ($urandom_range(0, 24) == 0)
			return NB'($urandom_range(0, 3));
		return raw_bits;
	endfunction

	task automatic random_phase(bit al, logic [7:0] deb, logic [15:0] hp, logic [15:0] rd,
			logic [7:0] base, int ticks, int long_max);
		configure(al, deb, hp, rd, base);
		cur_long = long_max;
		for (int t = 0; t < ticks; t++) begin
			if ($urandom_range(0, 59) == 0)
				drain();
			send_tick(next_levels());
		end
	endtask

	initial begin
		static logic [NB-1:0] quick_seq[13] = '{2'd3, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1,
			2'd3, 2'd3, 2'd0, 2'd3, 2'd3, 2'd3};
		static logic [NB-1:0] flip_seq[12]  = '{2'd3, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd2,
			2'd0, 2'd0, 2'd0, 2'd0, 2'd3};
		int errors;

		sb            = new();
		idle_cycles   = 0;
		send_calm     = 1'b0;
		recv_calm     = 1'b0;
		raw_bits      = '1;
		run_left      = '{default: 0};
		cur_need      = 5;
		cur_long      = 40;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		button_levels = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fastest timing: every hold level, both buttons at once, idle hold tick,
		// release summaries and a repeated first press
		configure(1'b0, 8'd1, 16'd1, 16'd1, 8'd1);
		foreach (quick_seq[k])
			send_tick(quick_seq[k]);

		// Zero debounce and periods, inverted active level, marks wrapping past 255
		configure(1'b1, 8'd0, 16'd0, 16'd0, 8'd255);
		foreach (flip_seq[k])
			send_tick(flip_seq[k]);

		random_phase(1'b0, 8'd1, 16'd1, 16'd1, 8'd1, 200, 40);
		random_phase(1'b1, 8'd3, 16'd2, 16'd4, 8'd3, 200, 40);
		random_phase(1'b0, 8'd255, 16'd65535, 16'd65535, 8'd251, 280, 280);
		random_phase(1'b1, 8'd2, 16'd1, 16'd3, 8'd255, 300, 400);
		random_phase(1'b0, 8'd4, 16'd7, 16'd10, 8'd100, 200, 60);
		random_phase(1'b1, 8'd1, 16'd0, 16'd0, 8'd1, 50, 40);

		drain();
		repeat (32) @(posedge clk);
		errors = sb.errors + sb.pending();
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
